>>> hw/rtl/gkg_pkg.sv
// shared types and constants of the gaussian kernel pipeline
package gkg_pkg;

   typedef struct packed {
      logic signed [31:0] gram_value;
      logic [30:0]        row_norm;
      logic [30:0]        col_norm;
   } req_type;

   typedef struct packed {
      logic [31:0] kernel_value;
      logic        saturated;
   } rsp_type;

   typedef enum logic [1:0] {
      KC_EXP,
      KC_ONE,
      KC_SAT,
      KC_ZERO
   } kclass_type;

   typedef struct packed {
      logic       valid;
      kclass_type kclass;
   } ctl_type;

   typedef struct packed {
      ctl_type     ctl;
      logic [36:0] xs;
   } scaled_type;

   typedef struct packed {
      logic [5:0]  shift;
      logic [31:0] r;
      logic [31:0] term;
      logic [32:0] sum;
   } series_data_type;

   typedef struct packed {
      ctl_type         ctl;
      series_data_type data;
   } series_type;

   localparam logic [31:0] LAMBDA_RESET = 32'h0100_0000;
   localparam logic [31:0] ONE_Q31      = 32'h8000_0000;
   localparam logic [31:0] LN2_Q32      = 32'hB172_17F8;
   localparam logic [16:0] INV_LN2      = 17'd94548;

   localparam int unsigned FRONT_STAGES  = 3;
   localparam int unsigned REDUCE_STAGES = 3;
   localparam int unsigned TERM_STAGES   = 3;
   localparam int unsigned BACK_STAGES   = 1;
   localparam int unsigned TERM_FIRST    = 2;
   localparam int unsigned TERM_LAST     = 24;
   localparam int unsigned LATENCY       = FRONT_STAGES + REDUCE_STAGES
                                           + (TERM_LAST - TERM_FIRST + 1) * TERM_STAGES
                                           + BACK_STAGES;

endpackage

>>> hw/rtl/gkg_front.sv
// distance, scaling by lambda and underflow detection
module gkg_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  gkg_pkg::req_type  req,
   input  logic [31:0]       lambda,
   output gkg_pkg::scaled_type scaled
);
   import gkg_pkg::*;

   logic signed [33:0] two_g;
   logic signed [33:0] distance;
   logic signed [33:0] neg_distance;
   ctl_type            s1_ctl_in, s1_ctl_ff, s2_ctl_ff, s3_ctl_in, s3_ctl_ff;
   logic [32:0]        mag_in, mag_ff;
   logic [47:0]        pp_lo_in, pp_lo_ff;
   logic [48:0]        pp_hi_in, pp_hi_ff;
   logic [64:0]        x;
   logic [36:0]        xs_ff;

   // stage 1: exponent argument and class
   always_comb begin
      two_g        = {req.gram_value[31], req.gram_value, 1'b0};
      distance     = two_g - $signed({3'b000, req.row_norm})
                     - $signed({3'b000, req.col_norm});
      neg_distance = -distance;
      mag_in       = neg_distance[32:0];
      s1_ctl_in.valid = start;
      if (distance == 34'sd0 || lambda == 32'd0) begin
         s1_ctl_in.kclass = KC_ONE;
      end else if (!distance[33]) begin
         s1_ctl_in.kclass = KC_SAT;
      end else begin
         s1_ctl_in.kclass = KC_EXP;
      end
   end

   // stage 2: partial products of magnitude times lambda
   always_comb begin
      pp_lo_in = 48'(mag_ff[15:0]) * 48'(lambda);
      pp_hi_in = 49'(mag_ff[32:16]) * 49'(lambda);
   end

   // stage 3: full product in q.40, underflow at 32.0
   always_comb begin
      x = {pp_hi_ff, 16'h0000} + {17'd0, pp_lo_ff};
      s3_ctl_in = s2_ctl_ff;
      if (s2_ctl_ff.kclass == KC_EXP && x[64:45] != 20'd0) begin
         s3_ctl_in.kclass = KC_ZERO;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ctl_ff <= '0;
         s2_ctl_ff <= '0;
         s3_ctl_ff <= '0;
      end else begin
         s1_ctl_ff <= s1_ctl_in;
         s2_ctl_ff <= s1_ctl_ff;
         s3_ctl_ff <= s3_ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff   <= mag_in;
      pp_lo_ff <= pp_lo_in;
      pp_hi_ff <= pp_hi_in;
      xs_ff    <= x[44:8];
   end

   assign scaled.ctl = s3_ctl_ff;
   assign scaled.xs  = xs_ff;

endmodule

>>> hw/rtl/gkg_reduce.sv
// range reduction by ln2 and series setup
module gkg_reduce (
   input  logic                clock,
   input  logic                reset,
   input  gkg_pkg::scaled_type scaled,
   output gkg_pkg::series_type series
);
   import gkg_pkg::*;

   ctl_type         s4_ctl_ff, s5_ctl_ff, s6_ctl_ff;
   logic [37:0]     est_prod;
   logic [5:0]      n_est_ff, n_est5_ff;
   logic [36:0]     xs4_ff;
   logic [37:0]     n_ln2;
   logic [37:0]     r0_full;
   logic [32:0]     r0_ff;
   logic [33:0]     sum_lo, sum_hi;
   logic [32:0]     r_hi;
   series_data_type s6_data_in, s6_data_ff;

   // stage 4: quotient estimate, low by at most one
   always_comb begin
      est_prod = 38'(scaled.xs[36:16]) * 38'(INV_LN2);
   end

   // stage 5: remainder of the estimate
   always_comb begin
      n_ln2   = 38'(n_est_ff) * 38'(LN2_Q32);
      r0_full = 38'(xs4_ff) - n_ln2;
   end

   // stage 6: correction and first series term
   always_comb begin
      r_hi   = r0_ff - 33'(LN2_Q32);
      sum_lo = 34'h1_0000_0000 - 34'(r0_ff);
      sum_hi = 34'h1_0000_0000 + 34'(LN2_Q32) - 34'(r0_ff);
      if (r0_ff >= 33'(LN2_Q32)) begin
         s6_data_in.shift = n_est5_ff + 6'd1;
         s6_data_in.r     = r_hi[31:0];
         s6_data_in.sum   = sum_hi[32:0];
      end else begin
         s6_data_in.shift = n_est5_ff;
         s6_data_in.r     = r0_ff[31:0];
         s6_data_in.sum   = sum_lo[32:0];
      end
      s6_data_in.term = s6_data_in.r;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_ctl_ff <= '0;
         s5_ctl_ff <= '0;
         s6_ctl_ff <= '0;
      end else begin
         s4_ctl_ff <= scaled.ctl;
         s5_ctl_ff <= s4_ctl_ff;
         s6_ctl_ff <= s5_ctl_ff;
      end
   end

   always_ff @(posedge clock) begin
      n_est_ff   <= est_prod[37:32];
      xs4_ff     <= scaled.xs;
      n_est5_ff  <= n_est_ff;
      r0_ff      <= r0_full[32:0];
      s6_data_ff <= s6_data_in;
   end

   assign series.ctl  = s6_ctl_ff;
   assign series.data = s6_data_ff;

endmodule

>>> hw/rtl/gkg_term.sv
// one taylor term of exp(-r): multiply, divide by k, accumulate
module gkg_term #(
   parameter int unsigned K = 2
) (
   input  logic                clock,
   input  logic                reset,
   input  gkg_pkg::series_type prev_stage,
   output gkg_pkg::series_type next_stage
);
   import gkg_pkg::*;

   localparam logic [31:0] RECIP    = 32'((64'd1 << 32) / K);
   localparam logic [4:0]  DIVISOR  = 5'(K);
   localparam bit          ADD_TERM = ((K % 2) == 0);

   ctl_type         a_ctl_ff, b_ctl_ff, c_ctl_ff;
   series_data_type a_data_ff, b_data_ff, c_data_in, c_data_ff;
   logic [63:0]     prod_in, prod_ff;
   logic [63:0]     qe_prod;
   logic [31:0]     p_ff, qe_ff;
   logic [36:0]     qk;
   logic [31:0]     rem;
   logic [31:0]     q;

   // stage a: previous term times r
   assign prod_in = 64'(prev_stage.data.term) * 64'(prev_stage.data.r);

   // stage b: reciprocal estimate of the quotient
   assign qe_prod = 64'(prod_ff[63:32]) * 64'(RECIP);

   // stage c: fix the estimate, add or subtract the term
   always_comb begin
      qk  = 37'(qe_ff) * 37'(DIVISOR);
      rem = p_ff - qk[31:0];
      q   = (rem >= 32'(DIVISOR)) ? qe_ff + 32'd1 : qe_ff;
      c_data_in      = b_data_ff;
      c_data_in.term = q;
      c_data_in.sum  = ADD_TERM ? b_data_ff.sum + 33'(q) : b_data_ff.sum - 33'(q);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_ctl_ff <= '0;
         b_ctl_ff <= '0;
         c_ctl_ff <= '0;
      end else begin
         a_ctl_ff <= prev_stage.ctl;
         b_ctl_ff <= a_ctl_ff;
         c_ctl_ff <= b_ctl_ff;
      end
   end

   always_ff @(posedge clock) begin
      a_data_ff <= prev_stage.data;
      prod_ff   <= prod_in;
      b_data_ff <= a_data_ff;
      p_ff      <= prod_ff[63:32];
      qe_ff     <= qe_prod[63:32];
      c_data_ff <= c_data_in;
   end

   assign next_stage.ctl  = c_ctl_ff;
   assign next_stage.data = c_data_ff;

endmodule

>>> hw/rtl/gkg_back.sv
// scaling by 2^-n with rounding and result select
module gkg_back (
   input  logic                clock,
   input  logic                reset,
   input  gkg_pkg::series_type series,
   output logic                rsp_strobe,
   output gkg_pkg::rsp_type    rsp_data
);
   import gkg_pkg::*;

   logic [6:0]  amt;
   logic [33:0] rounded;
   logic [33:0] scaled;
   logic [31:0] kval;
   rsp_type     rsp_in, rsp_ff;
   logic        strobe_ff;

   always_comb begin
      amt     = 7'(series.data.shift) + 7'd1;
      rounded = 34'(series.data.sum) + (34'd1 << series.data.shift);
      scaled  = rounded >> amt;
      kval    = (series.data.shift > 6'd32) ? 32'd0 : scaled[31:0];
      unique case (series.ctl.kclass)
         KC_EXP: begin
            rsp_in.kernel_value = kval;
            rsp_in.saturated    = 1'b0;
         end
         KC_ONE: begin
            rsp_in.kernel_value = ONE_Q31;
            rsp_in.saturated    = 1'b0;
         end
         KC_SAT: begin
            rsp_in.kernel_value = ONE_Q31;
            rsp_in.saturated    = 1'b1;
         end
         KC_ZERO: begin
            rsp_in.kernel_value = 32'd0;
            rsp_in.saturated    = 1'b0;
         end
         default: begin
            rsp_in.kernel_value = 32'd0;
            rsp_in.saturated    = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= series.ctl.valid;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule

>>> hw/rtl/gaussian_kernel_from_gram_top.sv
// top level of the gaussian kernel from gram entry pipeline
// takes one transaction every clock cycle and returns its result in order, on rsp_data
// for one cycle with rsp_strobe high; there is no backpressure and busy is high only while
// reset is asserted. most of the pipeline is the exp(-r) series:
// 23 term units in a row, each three stages (32x32 multiply, reciprocal divide by the term
// index, correct and accumulate), behind three stages of distance and lambda scaling and
// three of ln2 range reduction, and one output stage. csr_wdata sets lambda (unsigned q8.24,
// 1.0 after reset); write it only while no transaction is in flight
module gaussian_kernel_from_gram_top (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  gkg_pkg::req_type req_data,
   output logic             rsp_strobe,
   output gkg_pkg::rsp_type rsp_data,
   input  logic             csr_we,
   input  logic [31:0]      csr_wdata
);
   import gkg_pkg::*;

   logic [31:0] lambda_ff;
   scaled_type  scaled;
   series_type  chain [TERM_FIRST-1:TERM_LAST];

   assign busy = reset;

   always_ff @(posedge clock) begin
      if (reset) begin
         lambda_ff <= LAMBDA_RESET;
      end else if (csr_we) begin
         lambda_ff <= csr_wdata;
      end
   end

   gkg_front u_front (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .req    (req_data),
      .lambda (lambda_ff),
      .scaled (scaled)
   );

   gkg_reduce u_reduce (
      .clock  (clock),
      .reset  (reset),
      .scaled (scaled),
      .series (chain[TERM_FIRST-1])
   );

   for (genvar k = TERM_FIRST; k <= TERM_LAST; k++) begin : g_term
      gkg_term #(
         .K (k)
      ) u_term (
         .clock      (clock),
         .reset      (reset),
         .prev_stage (chain[k-1]),
         .next_stage (chain[k])
      );
   end

   gkg_back u_back (
      .clock      (clock),
      .reset      (reset),
      .series     (chain[TERM_LAST]),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

endmodule

>>> hw/rtl/gkg_checker.sv
// port-level checks of the gaussian kernel pipeline and their bind
module gkg_checker (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input logic             rsp_strobe,
   input gkg_pkg::rsp_type rsp_data
);
   import gkg_pkg::*;

   // every accepted transaction comes out after the fixed latency
   a_latency : assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##LATENCY rsp_strobe)
      else $error("accepted transaction produced no result at the expected cycle");

   // no result without a transaction accepted at the matching cycle
   a_no_spurious : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy, LATENCY))
      else $error("result strobe without a matching transaction");

   a_sat_is_one : assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.saturated) |-> (rsp_data.kernel_value == ONE_Q31))
      else $error("saturated result is not 1.0");

   a_range : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_data.kernel_value <= ONE_Q31))
      else $error("kernel value above 1.0");

endmodule

bind gaussian_kernel_from_gram_top gkg_checker u_checker (.*);
